[hdl/stt_pkg.sv]
// shared types, character codes and helper functions for the source text tokenizer
package stt_pkg;

   // input beat: one byte of source text
   typedef struct packed {
      logic [7:0] char_in;
      logic       text_last;
   } req_type;

   // result beat: one emitted byte with token markers
   typedef struct packed {
      logic [7:0] char_out;
      logic       has_char;
      logic       token_start;
      logic       run_last;
      logic       text_end;
   } rsp_type;

   // lexer modes
   localparam logic [1:0] MODE_NORMAL  = 2'd0;
   localparam logic [1:0] MODE_QUOTE   = 2'd1;
   localparam logic [1:0] MODE_COMMENT = 2'd2;

   // run classes
   localparam logic [1:0] CLS_OTHER = 2'd0;
   localparam logic [1:0] CLS_WORD  = 2'd1;
   localparam logic [1:0] CLS_NONE  = 2'd2;

   // character codes
   localparam logic [7:0] CH_QUOTE   = 8'h22;
   localparam logic [7:0] CH_NL      = 8'h0A;
   localparam logic [7:0] CH_SLASH   = 8'h2F;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_TAB     = 8'h09;
   localparam logic [7:0] CH_LBRACE  = 8'h7B;
   localparam logic [7:0] CH_RBRACE  = 8'h7D;
   localparam logic [7:0] CH_LBRACK  = 8'h5B;
   localparam logic [7:0] CH_RBRACK  = 8'h5D;
   localparam logic [7:0] CH_LPAREN  = 8'h28;
   localparam logic [7:0] CH_RPAREN  = 8'h29;
   localparam logic [7:0] CH_UNDER   = 8'h5F;
   localparam logic [7:0] CH_LOW_A   = 8'h61;
   localparam logic [7:0] CH_LOW_Z   = 8'h7A;
   localparam logic [7:0] CH_UP_A    = 8'h41;
   localparam logic [7:0] CH_UP_Z    = 8'h5A;
   localparam logic [7:0] CH_DIG_0   = 8'h30;
   localparam logic [7:0] CH_DIG_9   = 8'h39;

   // word characters are letters, digits and underscore
   function automatic logic [1:0] char_class(input logic [7:0] c);
      logic word;
      word = (c >= CH_LOW_A && c <= CH_LOW_Z) || (c >= CH_UP_A && c <= CH_UP_Z) ||
             (c >= CH_DIG_0 && c <= CH_DIG_9) || (c == CH_UNDER);
      return word ? CLS_WORD : CLS_OTHER;
   endfunction

   function automatic logic is_bracket(input logic [7:0] c);
      return (c == CH_LBRACE) || (c == CH_RBRACE) || (c == CH_LBRACK) ||
             (c == CH_RBRACK) || (c == CH_LPAREN) || (c == CH_RPAREN);
   endfunction

   // plain emitted byte, end markers filled in later
   function automatic rsp_type make_beat(input logic [7:0] c, input logic start);
      rsp_type b;
      b.char_out    = c;
      b.has_char    = 1'b1;
      b.token_start = start;
      b.run_last    = 1'b0;
      b.text_end    = 1'b0;
      return b;
   endfunction

endpackage

[hdl/stt_lex.sv]
// lexer state and per-byte step logic, up to two result beats per byte
module stt_lex
   import stt_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  req_type    item,
   output rsp_type    res_first,
   output rsp_type    res_second,
   output logic [1:0] res_cnt
);

   logic [1:0] mode_ff, mode_in;
   logic [7:0] prev_ff, prev_in;
   logic [1:0] cls_ff,  cls_in;
   logic       open_ff, open_in;
   logic       held_ff, held_in;

   rsp_type    res [2];
   logic [1:0] n;
   logic [7:0] c;
   logic [1:0] cls;
   logic       lst;

   // one step of the tokenizer
   always_comb begin
      mode_in = mode_ff;
      cls_in  = cls_ff;
      open_in = open_ff;
      held_in = held_ff;
      c       = item.char_in;
      prev_in = c;
      cls     = char_class(c);
      res[0]  = '0;
      res[1]  = '0;
      n       = 2'd0;
      lst     = 1'b0;

      if (mode_ff == MODE_QUOTE) begin
         res[n[0]] = make_beat(c, 1'b0);
         n = n + 2'd1;
         if (c == CH_QUOTE) mode_in = MODE_NORMAL;
      end else if (mode_ff == MODE_COMMENT) begin
         if (c == CH_NL) begin
            mode_in = MODE_NORMAL;
         end else begin
            res[n[0]] = make_beat(c, 1'b0);
            n = n + 2'd1;
         end
      end else if (c == CH_QUOTE) begin
         held_in = 1'b0;
         open_in = 1'b0;
         res[n[0]] = make_beat(c, 1'b1);
         n = n + 2'd1;
         mode_in = MODE_QUOTE;
      end else if (c == CH_NL) begin
         held_in = 1'b0;
         open_in = 1'b0;
         res[n[0]] = make_beat(c, 1'b1);
         n = n + 2'd1;
      end else if (c == CH_SLASH && prev_ff == CH_SLASH) begin
         // comment start: slash pair
         held_in = 1'b0;
         open_in = 1'b0;
         res[0] = make_beat(CH_SLASH, 1'b1);
         res[1] = make_beat(CH_SLASH, 1'b0);
         n = 2'd2;
         mode_in = MODE_COMMENT;
      end else begin
         // release a held lone slash
         if (held_ff) begin
            res[n[0]] = make_beat(CH_SLASH, 1'b1);
            n = n + 2'd1;
            held_in = 1'b0;
            open_in = 1'b1;
            cls_in  = CLS_OTHER;
         end
         if (c == CH_SPACE || c == CH_TAB) begin
            open_in = 1'b0;
            cls_in  = CLS_NONE;
         end else if (is_bracket(c)) begin
            res[n[0]] = make_beat(c, 1'b1);
            n = n + 2'd1;
            open_in = 1'b0;
            cls_in  = CLS_NONE;
         end else if (open_in && cls_in == cls) begin
            res[n[0]] = make_beat(c, 1'b0);
            n = n + 2'd1;
         end else if (c == CH_SLASH) begin
            held_in = 1'b1;
            open_in = 1'b1;
            cls_in  = CLS_OTHER;
         end else begin
            res[n[0]] = make_beat(c, 1'b1);
            n = n + 2'd1;
            open_in = 1'b1;
            cls_in  = cls;
         end
      end

      // end of text: flush held slash, bare marker, back to reset state
      if (item.text_last) begin
         if (held_in) begin
            res[n[0]] = make_beat(CH_SLASH, 1'b1);
            n = n + 2'd1;
         end
         if (n == 2'd0) n = 2'd1;
         lst = n[1];
         res[lst].text_end = 1'b1;
         mode_in = MODE_NORMAL;
         prev_in = '0;
         cls_in  = CLS_NONE;
         open_in = 1'b0;
         held_in = 1'b0;
      end
      lst = n[1];
      if (n != 2'd0) res[lst].run_last = 1'b1;
   end

   assign res_first  = res[0];
   assign res_second = res[1];
   assign res_cnt    = n;

   // lexer state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_NORMAL;
         prev_ff <= '0;
         cls_ff  <= CLS_NONE;
         open_ff <= 1'b0;
         held_ff <= 1'b0;
      end else if (step) begin
         mode_ff <= mode_in;
         prev_ff <= prev_in;
         cls_ff  <= cls_in;
         open_ff <= open_in;
         held_ff <= held_in;
      end
   end

endmodule

[hdl/source_text_tokenizer.sv]
// top level of the source text tokenizer: input register, lexer, two-entry result buffer
//
//   channel   ports                               direction   beat
//   req       req_valid, req_stall, req_data      in          one source byte, last flag
//   rsp       rsp_valid, rsp_stall, rsp_data      out         one emitted byte with markers
//
// a byte is taken into the input register, stepped through the lexer into the result
// buffer once that has room, and shown on rsp from the result buffer.
// one byte per cycle is sustained while rsp_stall is low and each byte gives at most
// one result; a two-result byte holds the result buffer, and the input, till both pop.
// reset is synchronous and returns the lexer to normal mode with both buffers empty.
// rsp_stall holds the result buffer and, while it is not empty, backs up into req_stall.
module source_text_tokenizer
   import stt_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic       in_valid_ff, in_valid_in;
   req_type    in_data_ff;
   logic [1:0] buf_cnt_ff, buf_cnt_in;
   rsp_type    buf0_ff, buf0_in;
   rsp_type    buf1_ff, buf1_in;

   logic       accept;
   logic       pop;
   logic       buf_free;
   logic       step;
   rsp_type    res_first;
   rsp_type    res_second;
   logic [1:0] res_cnt;

   // handshake control
   assign pop       = (buf_cnt_ff != 2'd0) && !rsp_stall;
   assign buf_free  = (buf_cnt_ff == 2'd0) || (buf_cnt_ff == 2'd1 && pop);
   assign step      = in_valid_ff && buf_free;
   assign req_stall = in_valid_ff && !buf_free;
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = buf_cnt_ff != 2'd0;
   assign rsp_data  = buf0_ff;

   stt_lex u_lex (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .item       (in_data_ff),
      .res_first  (res_first),
      .res_second (res_second),
      .res_cnt    (res_cnt)
   );

   // input register and result buffer next values
   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) in_valid_in = 1'b1;
      else if (step) in_valid_in = 1'b0;

      buf_cnt_in = buf_cnt_ff;
      buf0_in    = buf0_ff;
      buf1_in    = buf1_ff;
      if (step) begin
         buf_cnt_in = res_cnt;
         buf0_in    = res_first;
         buf1_in    = res_second;
      end else if (pop) begin
         if (buf_cnt_ff == 2'd2) begin
            buf0_in    = buf1_ff;
            buf_cnt_in = 2'd1;
         end else begin
            buf_cnt_in = 2'd0;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         buf_cnt_ff  <= 2'd0;
      end else begin
         in_valid_ff <= in_valid_in;
         buf_cnt_ff  <= buf_cnt_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) in_data_ff <= req_data;
      buf0_ff <= buf0_in;
      buf1_ff <= buf1_in;
   end

endmodule
